// ----- rtl/bps_pkg.sv -----
// Shared types and constants for the Blinn-Phong pixel shader core.
// Used by the iterative divide/square-root unit and the top level.
package bps_pkg;

    localparam int MAX_LIGHTS_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int UNIT_NUM_W = 34;
    localparam int UNIT_DEN_W = 18;
    localparam int UNIT_RES_W = 32;

    localparam logic [14:0] FX_ONE = 15'd16384;
    localparam logic [10:0] K_AMB  = 11'd1638;
    localparam logic [13:0] K_DIF  = 14'd9830;
    localparam logic [12:0] K_SPE  = 13'd4915;

    // ceil(2^32 / 255): exact quotient by 255 for dividends below 2^24
    localparam logic [24:0] DIV255_RECIP = 25'd16843010;

    localparam logic [1:0] CFG_VIEW_POSITION = 2'd0;
    localparam logic [1:0] CFG_SHININESS     = 2'd1;

    typedef enum logic {
        UNIT_DIV,
        UNIT_SQRT
    } unit_mode_t;

    typedef struct packed {
        logic                  start;
        unit_mode_t            mode;
        logic [UNIT_NUM_W-1:0] num;
        logic [UNIT_DEN_W-1:0] den;
    } unit_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [UNIT_RES_W-1:0] result;
    } unit_rsp_t;

endpackage

// ----- rtl/bps_iter_unit.sv -----
// Iterative restoring divider and digit-by-digit square root, one bit a cycle.
// Depends on bps_pkg for the request and response structs.
module bps_iter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  bps_pkg::unit_req_t  req,
    output bps_pkg::unit_rsp_t  rsp
);
    import bps_pkg::*;

    localparam int DIV_STEPS  = UNIT_NUM_W;
    localparam int SQRT_STEPS = UNIT_NUM_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 4;

    logic                  busy_reg;
    logic                  done_reg;
    unit_mode_t            mode_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [UNIT_NUM_W-1:0] shf_reg;
    logic [UNIT_DEN_W-1:0] den_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [UNIT_DEN_W:0]   div_rem_s;
    logic                  div_ge;
    logic [REM_W-1:0]      sq_rem_s;
    logic [REM_W-1:0]      sq_trial;
    logic                  sq_ge;
    logic [REM_W-1:0]      rem_next;
    logic [UNIT_NUM_W-1:0] shf_next;
    logic [ROOT_W-1:0]     root_next;
    logic                  last_step;

    always_comb
    begin
        div_rem_s = {rem_reg[UNIT_DEN_W-1:0], shf_reg[UNIT_NUM_W-1]};
        div_ge    = div_rem_s >= {1'b0, den_reg};
        sq_rem_s  = {rem_reg[REM_W-3:0], shf_reg[UNIT_NUM_W-1 -: 2]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        sq_ge     = sq_rem_s >= sq_trial;
        if (mode_reg == UNIT_DIV)
        begin
            rem_next  = div_ge ? REM_W'(div_rem_s - {1'b0, den_reg}) : REM_W'(div_rem_s);
            shf_next  = {shf_reg[UNIT_NUM_W-2:0], div_ge};
            root_next = root_reg;
            last_step = cnt_reg == CNT_W'(DIV_STEPS - 1);
        end
        else
        begin
            rem_next  = sq_ge ? sq_rem_s - sq_trial : sq_rem_s;
            shf_next  = {shf_reg[UNIT_NUM_W-3:0], 2'b00};
            root_next = {root_reg[ROOT_W-2:0], sq_ge};
            last_step = cnt_reg == CNT_W'(SQRT_STEPS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= UNIT_DIV;
            cnt_reg  <= '0;
            shf_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                cnt_reg  <= '0;
                shf_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                shf_reg  <= shf_next;
                root_reg <= root_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (mode_reg == UNIT_DIV)
            rsp.result = shf_reg[UNIT_RES_W-1:0];
        else
            rsp.result = UNIT_RES_W'(root_reg);
    end

endmodule

// ----- rtl/blinn_phong_pixel_shader_core.sv -----
// Blinn-Phong shading core: sequencer, shared multiplier and light accumulators.
// Depends on bps_pkg and bps_iter_unit.
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_stall     surface and light fields, last_light
//  out      source     out_valid / out_stall   shaded_red, shaded_green, shaded_blue
//  cfg      sink       cfg_write               cfg_index, cfg_data
//
// Each light runs nine normalizing quotients and three square roots on the
// shared divider, then the power loop over the exponent bits and the steps
// of each colour channel. A zero-length vector skips its quotients. A last
// light then also runs the final three quotients.
// Reset is asynchronous and leaves the block ready at once.
// A finished pixel waits in the output register; a new light is taken meanwhile.
module blinn_phong_pixel_shader_core #(
    parameter int MAX_LIGHTS  = bps_pkg::MAX_LIGHTS_DEF,
    parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] surface_colour,
    input  logic [47:0] surface_position,
    input  logic [47:0] surface_normal,
    input  logic [47:0] light_position,
    input  logic [47:0] light_intensity,
    input  logic        last_light,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  shaded_red,
    output logic [7:0]  shaded_green,
    output logic [7:0]  shaded_blue,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import bps_pkg::*;

    localparam int LW = $clog2(MAX_LIGHTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_NSQ, S_NACC, S_SQRT, S_SQRTW, S_NDIV, S_NDIVW, S_NEXT,
        S_DOT, S_DOTACC, S_DOTEND, S_POW, S_POWR, S_POWRW, S_POWB, S_POWBW,
        S_CHA, S_CHB, S_CHC, S_CHD, S_CHE, S_CHF, S_CHW,
        S_FIN, S_FINW, S_FINM, S_FINP, S_OUT
    } state_t;

    function automatic logic signed [16:0] coord_of(input logic [15:0] slot);
        logic signed [COORD_WIDTH-1:0] t;
        t = slot[COORD_WIDTH-1:0];
        return 17'(t);
    endfunction

    state_t                state_reg;
    logic [47:0]           view_reg;
    logic [7:0]            shin_reg;
    logic [23:0]           colour_reg;
    logic [47:0]           nrm_reg;
    logic [47:0]           inten_reg;
    logic                  last_reg;
    logic signed [16:0]    vec_reg [0:2];
    logic signed [16:0]    dl_reg  [0:2];
    logic signed [15:0]    v_reg   [0:2];
    logic signed [15:0]    l_reg   [0:2];
    logic signed [15:0]    h_reg   [0:2];
    logic [33:0]           sum_reg;
    logic [17:0]           len_reg;
    logic signed [34:0]    dsum_reg;
    logic [14:0]           ndl_reg;
    logic [14:0]           pr_reg;
    logic [14:0]           pb_reg;
    logic [7:0]            exp_reg;
    logic [28:0]           t1_reg;
    logic [16:0]           dif_reg;
    logic [14:0]           q_reg;
    logic [7:0]            res_reg [0:2];
    logic [23:0]           acc_reg [0:2];
    logic [LW-1:0]         lights_reg;
    logic [1:0]            idx_reg;
    logic [1:0]            which_reg;
    logic                  dsel_reg;
    logic                  out_valid_reg;
    logic [7:0]            red_reg;
    logic [7:0]            green_reg;
    logic [7:0]            blue_reg;
    logic signed [65:0]    prod_reg;

    logic signed [32:0]    mul_a;
    logic signed [32:0]    mul_b;
    unit_req_t             ureq;
    unit_rsp_t             ursp;

    logic                  in_accept;
    logic                  room;
    logic signed [16:0]    cur_vec;
    logic [16:0]           cur_mag;
    logic [7:0]            cur_c;
    logic [15:0]           cur_it;
    logic signed [15:0]    cur_n;
    logic signed [15:0]    nq;
    logic [14:0]           dot_val;
    logic [LW-1:0]         cnt;
    logic [25:0]           acc_sum;
    logic [23:0]           acc_sat;
    logic [14:0]           q_clamp;
    logic [22:0]           rnd;

    bps_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .rsp   (ursp)
    );

    assign in_stall  = state_reg != S_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign room      = lights_reg < LW'(MAX_LIGHTS);
    assign out_valid    = out_valid_reg;
    assign shaded_red   = red_reg;
    assign shaded_green = green_reg;
    assign shaded_blue  = blue_reg;

    always_comb
    begin
        cur_vec = vec_reg[idx_reg];
        cur_mag = cur_vec[16] ? 17'(-cur_vec) : 17'(cur_vec);
        case (idx_reg)
            2'd0:
            begin
                cur_c  = colour_reg[23:16];
                cur_it = inten_reg[15:0];
                cur_n  = nrm_reg[15:0];
            end
            2'd1:
            begin
                cur_c  = colour_reg[15:8];
                cur_it = inten_reg[31:16];
                cur_n  = nrm_reg[31:16];
            end
            default:
            begin
                cur_c  = colour_reg[7:0];
                cur_it = inten_reg[47:32];
                cur_n  = nrm_reg[47:32];
            end
        endcase
        nq = cur_vec[16] ? -16'(ursp.result[15:0]) : 16'(ursp.result[15:0]);
        if (dsum_reg <= 0)
            dot_val = '0;
        else if (dsum_reg[34:14] > 21'(FX_ONE))
            dot_val = FX_ONE;
        else
            dot_val = dsum_reg[28:14];
        cnt      = (lights_reg == '0) ? LW'(1) : lights_reg;
        acc_sum  = 26'(acc_reg[idx_reg]) + 26'(dif_reg) + 26'(prod_reg[43:28]);
        acc_sat  = (acc_sum > 26'hFFFFFF) ? 24'hFFFFFF : acc_sum[23:0];
        q_clamp  = (ursp.result > UNIT_RES_W'(FX_ONE)) ? FX_ONE : ursp.result[14:0];
        rnd      = 23'(prod_reg[21:0]) + 23'd8192;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_NSQ:
            begin
                mul_a = 33'(cur_vec);
                mul_b = 33'(cur_vec);
            end
            S_DOT:
            begin
                mul_a = 33'(cur_n);
                mul_b = dsel_reg ? 33'(h_reg[idx_reg]) : 33'(l_reg[idx_reg]);
            end
            S_POWR:
            begin
                mul_a = 33'(pr_reg);
                mul_b = 33'(pb_reg);
            end
            S_POWB:
            begin
                mul_a = 33'(pb_reg);
                mul_b = 33'(pb_reg);
            end
            S_CHA:
            begin
                mul_a = 33'(ndl_reg);
                mul_b = 33'(K_DIF);
            end
            S_CHB:
            begin
                mul_a = 33'(cur_c);
                mul_b = 33'(cur_it);
            end
            S_CHC:
            begin
                mul_a = 33'(t1_reg);
                mul_b = 33'(prod_reg[23:0]);
            end
            S_CHD:
            begin
                mul_a = 33'(prod_reg[51:28]);
                mul_b = 33'(DIV255_RECIP);
            end
            S_CHE:
            begin
                mul_a = 33'(cur_it);
                mul_b = 33'(pr_reg);
            end
            S_CHF:
            begin
                mul_a = 33'(prod_reg[30:0]);
                mul_b = 33'(K_SPE);
            end
            S_FINM:
            begin
                mul_a = 33'(q_reg);
                mul_b = 33'd255;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        ureq.start = 1'b0;
        ureq.mode  = UNIT_DIV;
        ureq.num   = '0;
        ureq.den   = '0;
        case (state_reg)
            S_SQRT:
            begin
                ureq.start = 1'b1;
                ureq.mode  = UNIT_SQRT;
                ureq.num   = sum_reg;
            end
            S_NDIV:
            begin
                ureq.start = len_reg != '0;
                ureq.num   = UNIT_NUM_W'({cur_mag, 14'd0});
                ureq.den   = len_reg;
            end
            S_FIN:
            begin
                ureq.start = 1'b1;
                ureq.num   = UNIT_NUM_W'(25'(acc_reg[idx_reg]) + 25'(K_AMB));
                ureq.den   = UNIT_DEN_W'(cnt);
            end
            default:
            begin
                ureq.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg <= '0;
            shin_reg <= 8'd32;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VIEW_POSITION: view_reg <= cfg_data;
                CFG_SHININESS:     shin_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            colour_reg    <= '0;
            nrm_reg       <= '0;
            inten_reg     <= '0;
            last_reg      <= 1'b0;
            sum_reg       <= '0;
            len_reg       <= '0;
            dsum_reg      <= '0;
            ndl_reg       <= '0;
            pr_reg        <= '0;
            pb_reg        <= '0;
            exp_reg       <= '0;
            t1_reg        <= '0;
            dif_reg       <= '0;
            q_reg         <= '0;
            lights_reg    <= '0;
            idx_reg       <= '0;
            which_reg     <= '0;
            dsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vec_reg[i] <= '0;
                dl_reg[i]  <= '0;
                v_reg[i]   <= '0;
                l_reg[i]   <= '0;
                h_reg[i]   <= '0;
                res_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        colour_reg <= surface_colour;
                        nrm_reg    <= surface_normal;
                        inten_reg  <= light_intensity;
                        last_reg   <= last_light;
                        for (int i = 0; i < 3; i++)
                        begin
                            vec_reg[i] <= coord_of(view_reg[16*i +: 16])
                                        - coord_of(surface_position[16*i +: 16]);
                            dl_reg[i]  <= coord_of(light_position[16*i +: 16])
                                        - coord_of(surface_position[16*i +: 16]);
                        end
                        which_reg <= '0;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        if (room)
                            state_reg <= S_NSQ;
                        else if (last_light)
                            state_reg <= S_FIN;
                    end
                end
                S_NSQ:
                    state_reg <= S_NACC;
                S_NACC:
                begin
                    sum_reg <= sum_reg + prod_reg[33:0];
                    if (idx_reg == 2'd2)
                        state_reg <= S_SQRT;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_NSQ;
                    end
                end
                S_SQRT:
                    state_reg <= S_SQRTW;
                S_SQRTW:
                begin
                    if (ursp.done)
                    begin
                        len_reg   <= ursp.result[17:0];
                        idx_reg   <= '0;
                        state_reg <= S_NDIV;
                    end
                end
                S_NDIV, S_NDIVW:
                begin
                    if ((state_reg == S_NDIV && len_reg == '0)
                        || (state_reg == S_NDIVW && ursp.done))
                    begin
                        case (which_reg)
                            2'd0:    v_reg[idx_reg] <= (len_reg == '0) ? 16'sd0 : nq;
                            2'd1:    l_reg[idx_reg] <= (len_reg == '0) ? 16'sd0 : nq;
                            default: h_reg[idx_reg] <= (len_reg == '0) ? 16'sd0 : nq;
                        endcase
                        if (idx_reg == 2'd2)
                            state_reg <= S_NEXT;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_NDIV;
                        end
                    end
                    else if (state_reg == S_NDIV)
                        state_reg <= S_NDIVW;
                end
                S_NEXT:
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                    case (which_reg)
                        2'd0:
                        begin
                            for (int i = 0; i < 3; i++)
                                vec_reg[i] <= dl_reg[i];
                            which_reg <= 2'd1;
                            state_reg <= S_NSQ;
                        end
                        2'd1:
                        begin
                            for (int i = 0; i < 3; i++)
                                vec_reg[i] <= 17'(v_reg[i]) + 17'(l_reg[i]);
                            which_reg <= 2'd2;
                            state_reg <= S_NSQ;
                        end
                        default:
                        begin
                            dsel_reg  <= 1'b0;
                            dsum_reg  <= '0;
                            state_reg <= S_DOT;
                        end
                    endcase
                end
                S_DOT:
                    state_reg <= S_DOTACC;
                S_DOTACC:
                begin
                    dsum_reg <= dsum_reg + 35'(prod_reg);
                    if (idx_reg == 2'd2)
                        state_reg <= S_DOTEND;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_DOT;
                    end
                end
                S_DOTEND:
                begin
                    idx_reg  <= '0;
                    dsum_reg <= '0;
                    if (!dsel_reg)
                    begin
                        ndl_reg   <= dot_val;
                        dsel_reg  <= 1'b1;
                        state_reg <= S_DOT;
                    end
                    else
                    begin
                        pb_reg    <= dot_val;
                        pr_reg    <= FX_ONE;
                        exp_reg   <= shin_reg;
                        state_reg <= S_POW;
                    end
                end
                S_POW:
                begin
                    if (exp_reg == '0)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CHA;
                    end
                    else if (exp_reg[0])
                        state_reg <= S_POWR;
                    else
                        state_reg <= S_POWB;
                end
                S_POWR:
                    state_reg <= S_POWRW;
                S_POWRW:
                begin
                    pr_reg    <= prod_reg[28:14];
                    state_reg <= S_POWB;
                end
                S_POWB:
                    state_reg <= S_POWBW;
                S_POWBW:
                begin
                    pb_reg    <= prod_reg[28:14];
                    exp_reg   <= exp_reg >> 1;
                    state_reg <= S_POW;
                end
                S_CHA:
                    state_reg <= S_CHB;
                S_CHB:
                begin
                    t1_reg    <= prod_reg[28:0];
                    state_reg <= S_CHC;
                end
                S_CHC:
                    state_reg <= S_CHD;
                S_CHD:
                    state_reg <= S_CHE;
                S_CHE:
                begin
                    dif_reg   <= prod_reg[48:32];
                    state_reg <= S_CHF;
                end
                S_CHF:
                    state_reg <= S_CHW;
                S_CHW:
                begin
                    acc_reg[idx_reg] <= acc_sat;
                    if (idx_reg == 2'd2)
                    begin
                        lights_reg <= lights_reg + 1'b1;
                        idx_reg    <= '0;
                        state_reg  <= last_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CHA;
                    end
                end
                S_FIN:
                    state_reg <= S_FINW;
                S_FINW:
                begin
                    if (ursp.done)
                    begin
                        q_reg     <= q_clamp;
                        state_reg <= S_FINM;
                    end
                end
                S_FINM:
                    state_reg <= S_FINP;
                S_FINP:
                begin
                    res_reg[idx_reg] <= rnd[21:14];
                    if (idx_reg == 2'd2)
                        state_reg <= S_OUT;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        red_reg       <= res_reg[0];
                        green_reg     <= res_reg[1];
                        blue_reg      <= res_reg[2];
                        out_valid_reg <= 1'b1;
                        lights_reg    <= '0;
                        for (int i = 0; i < 3; i++)
                            acc_reg[i] <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_lights_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        lights_reg <= LW'(MAX_LIGHTS))
        else $error("light count above limit");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        ureq.start |-> !ursp.busy)
        else $error("shared unit started while busy");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (room || last_light)) |=> in_stall)
        else $error("accepted transaction left no trace");

    a_fin_has_lights: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (lights_reg != '0))
        else $error("final divide with no lights");

endmodule
